@@ src/rmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rmsc_pkg
// Types, codes and constants shared by the radio modem session controller.
// ----------------------------------------------------------------------------
package rmsc_pkg;

  localparam logic [3:0] INIT_STEPS    = 4'd11;
  localparam logic [7:0] MAX_PORT      = 8'd223;
  localparam logic [7:0] LIMIT_DEFAULT = 8'd242;
  localparam logic [7:0] LIMIT_STEP    = 8'd2;
  localparam logic [2:0] RESET_CNT_MAX = 3'd7;

  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CREDENTIALS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_WAIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_WAIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESENDS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIMIT    = 3'd5;

  localparam logic [19:0] RESP_TIMEOUT_RST = 20'd30000;
  localparam logic [19:0] FAST_WAIT_RST    = 20'd10;
  localparam logic [21:0] SLOW_WAIT_RST    = 22'd900000;
  localparam logic [2:0]  MAX_RESENDS_RST  = 3'd5;
  localparam logic [2:0]  FAST_LIMIT_RST   = 3'd2;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_REPLY  = 3'd1;
  localparam logic [2:0] OP_SEND   = 3'd2;
  localparam logic [2:0] OP_START  = 3'd3;
  localparam logic [2:0] OP_RELOAD = 3'd4;

  localparam logic [2:0] RK_INIT_DONE = 3'd0;
  localparam logic [2:0] RK_OK        = 3'd1;
  localparam logic [2:0] RK_JOINED    = 3'd2;
  localparam logic [2:0] RK_ACK       = 3'd3;
  localparam logic [2:0] RK_ERROR     = 3'd4;
  localparam logic [2:0] RK_DOWNLINK  = 3'd5;
  localparam logic [2:0] RK_OTHER     = 3'd6;
  localparam logic [2:0] RK_MALFORMED = 3'd7;

  localparam logic [7:0] ERR_NO_NETWORK   = 8'd80;
  localparam logic [7:0] ERR_TOO_LONG     = 8'd87;
  localparam logic [7:0] ERR_NOT_JOINED_A = 8'd95;
  localparam logic [7:0] ERR_NOT_JOINED_B = 8'd96;
  localparam logic [7:0] ERR_BUSY_A       = 8'd97;
  localparam logic [7:0] ERR_BUSY_B       = 8'd98;
  localparam logic [7:0] ERR_IGNORE_A     = 8'd100;
  localparam logic [7:0] ERR_SIZE         = 8'd101;
  localparam logic [7:0] ERR_IGNORE_B     = 8'd104;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_INIT    = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_JOIN    = 3'd3;
  localparam logic [2:0] CMD_ALIVE   = 3'd4;
  localparam logic [2:0] CMD_SEND    = 3'd5;
  localparam logic [2:0] CMD_RESEND  = 3'd6;

  localparam logic [1:0] ACK_NONE = 2'd0;
  localparam logic [1:0] ACK_OK   = 2'd1;
  localparam logic [1:0] ACK_FAIL = 2'd2;

  localparam logic [3:0] M_OFF      = 4'd0;
  localparam logic [3:0] M_WINIT    = 4'd1;
  localparam logic [3:0] M_WINITOK  = 4'd2;
  localparam logic [3:0] M_WRESTART = 4'd3;
  localparam logic [3:0] M_WJOIN    = 4'd4;
  localparam logic [3:0] M_WOK      = 4'd5;
  localparam logic [3:0] M_WACK     = 4'd6;
  localparam logic [3:0] M_IDLE     = 4'd7;
  localparam logic [3:0] M_UNCONF   = 4'd8;

  typedef struct packed {
    logic        credentials_valid;
    logic [19:0] response_timeout_ms;
    logic [19:0] fast_reset_wait_ms;
    logic [21:0] slow_reset_wait_ms;
    logic [2:0]  max_resends;
    logic [2:0]  fast_reset_limit;
  } rmsc_cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] reply_kind;
    logic [7:0] error_code;
  } rmsc_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] init_index;
    logic [7:0] port;
    logic [1:0] ack_report;
    logic       chip_enable;
    logic [3:0] session_state;
    logic       connected;
    logic       request_accepted;
    logic [7:0] payload_limit;
  } rmsc_result_t;

  function automatic logic [7:0] port_after(input logic [7:0] last);
    logic [7:0] p;
    p = last + 8'd1;
    if (p > MAX_PORT || p == 8'd0) begin
      p = 8'd0;
    end
    return p;
  endfunction

endpackage

@@ src/rmsc_item_if.sv @@
// ----------------------------------------------------------------------------
// rmsc_item_if
// Input channel: events and module replies into the session controller.
// ----------------------------------------------------------------------------
interface rmsc_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [2:0] reply_kind;
  logic [7:0] error_code;

  modport source (output valid, op, reply_kind, error_code, input ready);
  modport sink (input valid, op, reply_kind, error_code, output ready);
endinterface

@@ src/rmsc_result_if.sv @@
// ----------------------------------------------------------------------------
// rmsc_result_if
// Output channel: one result per input transaction.
// ----------------------------------------------------------------------------
interface rmsc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] init_index;
  logic [7:0] port;
  logic [1:0] ack_report;
  logic       chip_enable;
  logic [3:0] session_state;
  logic       connected;
  logic       request_accepted;
  logic [7:0] payload_limit;

  modport source (
    output valid, command, init_index, port, ack_report, chip_enable,
           session_state, connected, request_accepted, payload_limit,
    input  ready
  );
  modport sink (
    input  valid, command, init_index, port, ack_report, chip_enable,
           session_state, connected, request_accepted, payload_limit,
    output ready
  );
endinterface

@@ src/rmsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rmsc_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rmsc_cfg_regs import rmsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output rmsc_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.credentials_valid   <= 1'b0;
      cfg.response_timeout_ms <= RESP_TIMEOUT_RST;
      cfg.fast_reset_wait_ms  <= FAST_WAIT_RST;
      cfg.slow_reset_wait_ms  <= SLOW_WAIT_RST;
      cfg.max_resends         <= MAX_RESENDS_RST;
      cfg.fast_reset_limit    <= FAST_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CREDENTIALS:  cfg.credentials_valid   <= cfg_data[0];
        CFG_RESP_TIMEOUT: cfg.response_timeout_ms <= cfg_data[19:0];
        CFG_FAST_WAIT:    cfg.fast_reset_wait_ms  <= cfg_data[19:0];
        CFG_SLOW_WAIT:    cfg.slow_reset_wait_ms  <= cfg_data[21:0];
        CFG_MAX_RESENDS:  cfg.max_resends         <= cfg_data[2:0];
        CFG_FAST_LIMIT:   cfg.fast_reset_limit    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/rmsc_core.sv @@
// ----------------------------------------------------------------------------
// rmsc_core
// Session state registers and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module rmsc_core import rmsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  rmsc_item_t   item,
  input  rmsc_cfg_t    cfg,
  output rmsc_result_t res
);

  logic [3:0]  session_mode, session_mode_next;
  logic [3:0]  step_idx, step_idx_next;
  logic [2:0]  resend_cnt, resend_cnt_next;
  logic [2:0]  reset_cnt, reset_cnt_next;
  logic        slow_backoff, slow_backoff_next;
  logic [31:0] ms_since_reply, ms_since_reply_next;
  logic [31:0] ms_since_off, ms_since_off_next;
  logic        backup_held, backup_held_next;
  logic [7:0]  last_port, last_port_next;
  logic [7:0]  limit_now, limit_now_next;

  logic        reset_req;
  logic        retry_req;
  logic        is_conn;
  logic        is_ok;
  logic [21:0] off_wait;
  logic [2:0]  cmd;
  logic [3:0]  idx;
  logic [7:0]  port;
  logic [1:0]  ack;
  logic        acc;

  always_comb begin
    session_mode_next   = session_mode;
    step_idx_next       = step_idx;
    resend_cnt_next     = resend_cnt;
    reset_cnt_next      = reset_cnt;
    slow_backoff_next   = slow_backoff;
    ms_since_reply_next = ms_since_reply;
    ms_since_off_next   = ms_since_off;
    backup_held_next    = backup_held;
    last_port_next      = last_port;
    limit_now_next      = limit_now;
    reset_req = 1'b0;
    retry_req = 1'b0;
    cmd  = CMD_NONE;
    idx  = 4'd0;
    port = 8'd0;
    ack  = ACK_NONE;
    acc  = 1'b0;
    is_conn = session_mode == M_WOK || session_mode == M_WACK || session_mode == M_IDLE;
    is_ok   = item.reply_kind == RK_OK || item.reply_kind == RK_JOINED;
    off_wait = slow_backoff ? cfg.slow_reset_wait_ms : {2'b00, cfg.fast_reset_wait_ms};

    case (item.op)
      OP_TICK: begin
        if (ms_since_reply != 32'hFFFF_FFFF) begin
          ms_since_reply_next = ms_since_reply + 32'd1;
        end
        if (ms_since_off != 32'hFFFF_FFFF) begin
          ms_since_off_next = ms_since_off + 32'd1;
        end
        if (session_mode == M_OFF) begin
          if (ms_since_off_next > {10'd0, off_wait}) begin
            session_mode_next = M_WINIT;
            step_idx_next     = 4'd0;
          end
        end else if (session_mode != M_IDLE && session_mode != M_UNCONF) begin
          if (ms_since_reply_next > {12'd0, cfg.response_timeout_ms}) begin
            if (session_mode == M_WOK || session_mode == M_WACK) begin
              ack = ACK_FAIL;
            end
            reset_req = 1'b1;
          end
        end
      end
      OP_REPLY: begin
        ms_since_reply_next = 32'd0;
        if (item.reply_kind == RK_ERROR) begin
          case (item.error_code)
            ERR_NO_NETWORK, ERR_BUSY_A, ERR_BUSY_B: retry_req = 1'b1;
            ERR_TOO_LONG, ERR_SIZE: begin
              limit_now_next = (limit_now >= LIMIT_STEP) ? limit_now - LIMIT_STEP : 8'd0;
              ack = ACK_FAIL;
              reset_req = 1'b1;
            end
            ERR_NOT_JOINED_A, ERR_NOT_JOINED_B: begin
              if (is_conn) begin
                retry_req = 1'b1;
              end else begin
                reset_req = 1'b1;
              end
            end
            ERR_IGNORE_A, ERR_IGNORE_B: ;
            default: reset_req = 1'b1;
          endcase
        end else if (item.reply_kind == RK_DOWNLINK || item.reply_kind == RK_MALFORMED) begin
        end else if (item.reply_kind == RK_ACK && session_mode != M_WACK) begin
        end else begin
          case (session_mode)
            M_WINIT: begin
              if (item.reply_kind == RK_INIT_DONE) begin
                session_mode_next = M_WINITOK;
                idx = step_idx;
                step_idx_next = step_idx + 4'd1;
                cmd = CMD_INIT;
              end
            end
            M_WINITOK: begin
              if (is_ok) begin
                if (step_idx == INIT_STEPS) begin
                  session_mode_next = M_WRESTART;
                  cmd = CMD_RESTART;
                end else if (step_idx < INIT_STEPS) begin
                  idx = step_idx;
                  step_idx_next = step_idx + 4'd1;
                  cmd = CMD_INIT;
                end
              end
            end
            M_WRESTART: begin
              if (item.reply_kind == RK_INIT_DONE) begin
                session_mode_next = M_WJOIN;
                cmd = CMD_JOIN;
              end
            end
            M_WJOIN: begin
              if (item.reply_kind == RK_JOINED) begin
                session_mode_next = M_WOK;
                last_port_next = port_after(last_port);
                port = last_port_next;
                cmd = CMD_ALIVE;
              end
            end
            M_WOK: begin
              if (is_ok) begin
                session_mode_next = M_WACK;
              end
            end
            M_WACK: begin
              if (item.reply_kind == RK_ACK) begin
                session_mode_next = M_IDLE;
                reset_cnt_next    = 3'd0;
                resend_cnt_next   = 3'd0;
                backup_held_next  = 1'b0;
                ack = ACK_OK;
              end
            end
            default: ;
          endcase
        end
      end
      OP_SEND: begin
        if (session_mode == M_IDLE) begin
          session_mode_next = M_WOK;
          last_port_next = port_after(last_port);
          port = last_port_next;
          cmd = CMD_SEND;
          ms_since_reply_next = 32'd0;
          backup_held_next = 1'b1;
          acc = 1'b1;
        end
      end
      OP_START: begin
        if (session_mode == M_OFF) begin
          if (cfg.credentials_valid) begin
            session_mode_next = M_WINIT;
            step_idx_next     = 4'd0;
          end else begin
            session_mode_next = M_UNCONF;
          end
        end
      end
      OP_RELOAD: begin
        if (cfg.credentials_valid) begin
          reset_cnt_next = 3'd0;
          reset_req = 1'b1;
        end
      end
      default: ;
    endcase

    // retry: resend from backup or give up
    if (retry_req) begin
      if (resend_cnt >= cfg.max_resends) begin
        resend_cnt_next = 3'd0;
        reset_req = 1'b1;
        ack = ACK_FAIL;
      end else begin
        resend_cnt_next = resend_cnt + 3'd1;
        if (backup_held) begin
          session_mode_next = M_WOK;
          last_port_next = port_after(last_port);
          port = last_port_next;
          cmd = CMD_RESEND;
          ms_since_reply_next = 32'd0;
        end
      end
    end

    // module power-off, ignored while already off
    if (reset_req && session_mode != M_OFF) begin
      session_mode_next = M_OFF;
      ms_since_off_next = 32'd0;
      if (reset_cnt_next < RESET_CNT_MAX) begin
        reset_cnt_next = reset_cnt_next + 3'd1;
      end
      slow_backoff_next = reset_cnt_next > cfg.fast_reset_limit;
    end

    res.command          = cmd;
    res.init_index       = idx;
    res.port             = port;
    res.ack_report       = ack;
    res.chip_enable      = session_mode_next != M_OFF && session_mode_next != M_UNCONF;
    res.session_state    = session_mode_next;
    res.connected        = session_mode_next == M_WOK || session_mode_next == M_WACK ||
                           session_mode_next == M_IDLE;
    res.request_accepted = acc;
    res.payload_limit    = limit_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_mode   <= M_OFF;
      step_idx       <= 4'd0;
      resend_cnt     <= 3'd0;
      reset_cnt      <= 3'd0;
      slow_backoff   <= 1'b0;
      ms_since_reply <= 32'd0;
      ms_since_off   <= 32'd0;
      backup_held    <= 1'b0;
      last_port      <= 8'd0;
      limit_now      <= LIMIT_DEFAULT;
    end else if (accept) begin
      session_mode   <= session_mode_next;
      step_idx       <= step_idx_next;
      resend_cnt     <= resend_cnt_next;
      reset_cnt      <= reset_cnt_next;
      slow_backoff   <= slow_backoff_next;
      ms_since_reply <= ms_since_reply_next;
      ms_since_off   <= ms_since_off_next;
      backup_held    <= backup_held_next;
      last_port      <= last_port_next;
      limit_now      <= limit_now_next;
    end
  end

endmodule

@@ src/rmsc_out_reg.sv @@
// ----------------------------------------------------------------------------
// rmsc_out_reg
// Result register; loads a new result whenever the slot is free or draining.
// ----------------------------------------------------------------------------
module rmsc_out_reg import rmsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  rmsc_result_t         res,
  output logic                 free,
  rmsc_result_if.source        result
);

  logic         valid;
  rmsc_result_t held;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.valid            = valid;
  assign result.command          = held.command;
  assign result.init_index       = held.init_index;
  assign result.port             = held.port;
  assign result.ack_report       = held.ack_report;
  assign result.chip_enable      = held.chip_enable;
  assign result.session_state    = held.session_state;
  assign result.connected        = held.connected;
  assign result.request_accepted = held.request_accepted;
  assign result.payload_limit    = held.payload_limit;

endmodule

@@ src/radio_modem_session_controller.sv @@
// ----------------------------------------------------------------------------
// radio_modem_session_controller
// Each result is registered, valid in the cycle after its input is accepted.
// Throughput: 1 transaction per cycle while the result register drains.
// Reset: synchronous; session off, counters zero, limit 242, result empty.
// ----------------------------------------------------------------------------
module radio_modem_session_controller import rmsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rmsc_item_if.sink             item,
  rmsc_result_if.source         result
);

  rmsc_cfg_t    cfg;
  rmsc_item_t   cur_item;
  rmsc_result_t res;
  logic         free;
  logic         accept;

  assign item.ready = free;
  assign accept     = item.valid && free;

  assign cur_item.op         = item.op;
  assign cur_item.reply_kind = item.reply_kind;
  assign cur_item.error_code = item.error_code;

  rmsc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rmsc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (cur_item),
    .cfg    (cfg),
    .res    (res)
  );

  rmsc_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .res    (res),
    .free   (free),
    .result (result)
  );

  a_accept_gives_result: assert property (
    @(posedge clk) disable iff (rst) accept |=> result.valid
  ) else $error("accepted transaction produced no result");

  a_request_goes_wait_ok: assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && result.request_accepted) |->
      (result.command == CMD_SEND && result.session_state == M_WOK)
  ) else $error("accepted request without send command");

  a_port_only_on_send: assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && result.port != 8'd0) |->
      (result.command == CMD_ALIVE || result.command == CMD_SEND ||
       result.command == CMD_RESEND)
  ) else $error("port reported without a send");

  a_connected_powered: assert property (
    @(posedge clk) disable iff (rst)
    (result.valid && result.connected) |-> result.chip_enable
  ) else $error("connected while module powered off");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radio modem session controller. A queue of
// events is built phase by phase, each phase under its own register setting,
// and every event is run through a local model of the session as it is
// queued. A driver feeds the events with random gaps, a monitor takes results
// with random stalls and compares every field against the predicted result.
// ----------------------------------------------------------------------------
module tb;
  import rmsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rmsc_item_if   ev_if ();
  rmsc_result_if res_if ();

  radio_modem_session_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (ev_if),
    .result    (res_if)
  );

  // model configuration
  logic        c_creds;
  logic [19:0] c_timeout;
  logic [19:0] c_fast_wait;
  logic [21:0] c_slow_wait;
  logic [2:0]  c_max_resends;
  logic [2:0]  c_fast_limit;

  // model session state
  logic [3:0]  p_mode;
  logic [3:0]  p_init_step;
  logic [2:0]  p_resends;
  logic [2:0]  p_resets;
  logic        p_slow;
  logic [31:0] p_ms_reply;
  logic [31:0] p_ms_off;
  logic        p_backup;
  logic [7:0]  p_port;
  logic [7:0]  p_limit;
  rmsc_result_t p_res;

  rmsc_item_t   pending_events[$];
  rmsc_result_t staged_results[$];
  rmsc_result_t expected_results[$];

  logic calm;
  int   send_gap;
  int   stall_left;
  int   idle_cycles;
  int   n_fail;
  int   n_events;
  int   n_results;
  int   n_acked;
  int   n_resends;

  function automatic logic is_linked(input logic [3:0] m);
    return m == M_WOK || m == M_WACK || m == M_IDLE;
  endfunction

  function automatic void rotate_port();
    p_port = (p_port >= MAX_PORT) ? 8'd0 : p_port + 8'd1;
    p_res.port = p_port;
  endfunction

  function automatic void issue(input logic [2:0] cmd);
    p_res.command = cmd;
    p_ms_reply = '0;
  endfunction

  function automatic void power_up();
    p_mode = M_WINIT;
    p_init_step = '0;
  endfunction

  function automatic void power_down();
    if (p_mode != M_OFF) begin
      p_mode = M_OFF;
      p_ms_off = '0;
      if (p_resets != RESET_CNT_MAX) p_resets = p_resets + 3'd1;
      p_slow = (p_resets > c_fast_limit);
    end
  endfunction

  function automatic void retry_send();
    if (p_resends >= c_max_resends) begin
      p_resends = '0;
      power_down();
      p_res.ack_report = ACK_FAIL;
    end else begin
      p_resends = p_resends + 3'd1;
      if (p_backup) begin
        p_mode = M_WOK;
        rotate_port();
        issue(CMD_RESEND);
      end
    end
  endfunction

  function automatic rmsc_result_t predict_session_result(input rmsc_item_t ev);
    logic        is_ok;
    logic [21:0] off_wait;
    p_res = '0;
    case (ev.op)
      OP_TICK: begin
        if (p_ms_reply != 32'hFFFF_FFFF) p_ms_reply = p_ms_reply + 32'd1;
        if (p_ms_off != 32'hFFFF_FFFF) p_ms_off = p_ms_off + 32'd1;
        off_wait = p_slow ? c_slow_wait : {2'b00, c_fast_wait};
        if (p_mode == M_OFF) begin
          if (p_ms_off > off_wait) power_up();
        end else if (p_mode != M_IDLE && p_mode != M_UNCONF) begin
          if (p_ms_reply > c_timeout) begin
            if (p_mode == M_WOK || p_mode == M_WACK) p_res.ack_report = ACK_FAIL;
            power_down();
          end
        end
      end
      OP_REPLY: begin
        is_ok = (ev.reply_kind == RK_OK) || (ev.reply_kind == RK_JOINED);
        p_ms_reply = '0;
        if (ev.reply_kind == RK_ERROR) begin
          case (ev.error_code)
            ERR_NO_NETWORK, ERR_BUSY_A, ERR_BUSY_B: retry_send();
            ERR_TOO_LONG, ERR_SIZE: begin
              p_limit = (p_limit >= LIMIT_STEP) ? p_limit - LIMIT_STEP : 8'd0;
              p_res.ack_report = ACK_FAIL;
              power_down();
            end
            ERR_NOT_JOINED_A, ERR_NOT_JOINED_B: begin
              if (is_linked(p_mode)) retry_send();
              else power_down();
            end
            ERR_IGNORE_A, ERR_IGNORE_B: begin
            end
            default: power_down();
          endcase
        end else if (!(ev.reply_kind == RK_DOWNLINK || ev.reply_kind == RK_MALFORMED ||
                       (ev.reply_kind == RK_ACK && p_mode != M_WACK))) begin
          case (p_mode)
            M_WINIT: begin
              if (ev.reply_kind == RK_INIT_DONE) begin
                p_mode = M_WINITOK;
                p_res.init_index = p_init_step;
                p_init_step = p_init_step + 4'd1;
                issue(CMD_INIT);
              end
            end
            M_WINITOK: begin
              if (is_ok) begin
                if (p_init_step == INIT_STEPS) begin
                  p_mode = M_WRESTART;
                  issue(CMD_RESTART);
                end else if (p_init_step < INIT_STEPS) begin
                  p_res.init_index = p_init_step;
                  p_init_step = p_init_step + 4'd1;
                  issue(CMD_INIT);
                end
              end
            end
            M_WRESTART: begin
              if (ev.reply_kind == RK_INIT_DONE) begin
                p_mode = M_WJOIN;
                issue(CMD_JOIN);
              end
            end
            M_WJOIN: begin
              if (ev.reply_kind == RK_JOINED) begin
                p_mode = M_WOK;
                rotate_port();
                issue(CMD_ALIVE);
              end
            end
            M_WOK: begin
              if (is_ok) p_mode = M_WACK;
            end
            M_WACK: begin
              if (ev.reply_kind == RK_ACK) begin
                p_mode = M_IDLE;
                p_resets = '0;
                p_resends = '0;
                p_backup = 1'b0;
                p_res.ack_report = ACK_OK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_SEND: begin
        if (p_mode == M_IDLE) begin
          p_mode = M_WOK;
          rotate_port();
          issue(CMD_SEND);
          p_backup = 1'b1;
          p_res.request_accepted = 1'b1;
        end
      end
      OP_START: begin
        if (p_mode == M_OFF) begin
          if (c_creds) power_up();
          else p_mode = M_UNCONF;
        end
      end
      OP_RELOAD: begin
        if (c_creds) begin
          p_resets = '0;
          power_down();
        end
      end
      default: begin
      end
    endcase
    p_res.chip_enable   = (p_mode != M_OFF) && (p_mode != M_UNCONF);
    p_res.session_state = p_mode;
    p_res.connected     = is_linked(p_mode);
    p_res.payload_limit = p_limit;
    return p_res;
  endfunction

  function automatic void queue_event(input rmsc_item_t ev);
    pending_events.push_back(ev);
    staged_results.push_back(predict_session_result(ev));
  endfunction

  // mostly the reply the session is waiting for, with errors and noise mixed in
  function automatic rmsc_item_t pick_event();
    rmsc_item_t  ev;
    int          roll;
    logic [21:0] off_wait;
    ev.op = OP_REPLY;
    ev.reply_kind = 3'($urandom_range(0, 7));
    ev.error_code = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    off_wait = p_slow ? c_slow_wait : {2'b00, c_fast_wait};
    if (roll < 10) begin
      ev.op = 3'($urandom_range(0, 7));
      return ev;
    end
    if (roll < 22) begin
      ev.reply_kind = RK_ERROR;
      case ($urandom_range(0, 10))
        0: ev.error_code = ERR_NO_NETWORK;
        1: ev.error_code = ERR_TOO_LONG;
        2: ev.error_code = ERR_NOT_JOINED_A;
        3: ev.error_code = ERR_NOT_JOINED_B;
        4: ev.error_code = ERR_BUSY_A;
        5: ev.error_code = ERR_BUSY_B;
        6: ev.error_code = ERR_IGNORE_A;
        7: ev.error_code = ERR_SIZE;
        8: ev.error_code = ERR_IGNORE_B;
        default: begin
        end
      endcase
      return ev;
    end
    case (p_mode)
      M_OFF:                ev.op = ({10'd0, off_wait} > p_ms_off + 32'd40) ? OP_START : OP_TICK;
      M_UNCONF:             ev.op = (roll < 70) ? OP_RELOAD : OP_TICK;
      M_WINIT, M_WRESTART:  ev.reply_kind = RK_INIT_DONE;
      M_WINITOK:            ev.reply_kind = (roll < 80) ? RK_OK : RK_JOINED;
      M_WJOIN:              ev.reply_kind = RK_JOINED;
      M_WOK:                ev.reply_kind = RK_OK;
      M_WACK:               ev.reply_kind = RK_ACK;
      M_IDLE:               ev.op = (roll < 70) ? OP_SEND : OP_TICK;
      default:              ev.op = OP_TICK;
    endcase
    return ev;
  endfunction

  task automatic queue_random(input int count);
    int made;
    made = 0;
    while (made < count) begin
      if (p_mode >= M_WINIT && p_mode <= M_WACK && c_timeout < 20'd60 &&
          $urandom_range(0, 24) == 0) begin
        // silence past the response timeout
        repeat (int'(c_timeout) + 2) begin
          queue_event({OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))});
        end
        made += int'(c_timeout) + 2;
      end else begin
        queue_event(pick_event());
        made++;
      end
    end
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || staged_results.size() != 0 ||
           expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_CREDENTIALS:  c_creds       = data[0];
      CFG_RESP_TIMEOUT: c_timeout     = data[19:0];
      CFG_FAST_WAIT:    c_fast_wait   = data[19:0];
      CFG_SLOW_WAIT:    c_slow_wait   = data[21:0];
      CFG_MAX_RESENDS:  c_max_resends = data[2:0];
      CFG_FAST_LIMIT:   c_fast_limit  = data[2:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(input logic creds, input int timeout_ms, input int fast_ms,
                                input int slow_ms, input int resends, input int fast_lim);
    drain();
    write_reg(CFG_CREDENTIALS, CFG_DATA_W'(creds));
    write_reg(CFG_RESP_TIMEOUT, CFG_DATA_W'(timeout_ms));
    write_reg(CFG_FAST_WAIT, CFG_DATA_W'(fast_ms));
    write_reg(CFG_SLOW_WAIT, CFG_DATA_W'(slow_ms));
    write_reg(CFG_MAX_RESENDS, CFG_DATA_W'(resends));
    write_reg(CFG_FAST_LIMIT, CFG_DATA_W'(fast_lim));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  always #10 clk = ~clk;

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      ev_if.valid <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        void'(pending_events.pop_front());
        expected_results.push_back(staged_results.pop_front());
        n_events++;
      end
      if (!(ev_if.valid && !ev_if.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          ev_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 18);
          ev_if.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          ev_if.valid      <= 1'b1;
          ev_if.op         <= pending_events[0].op;
          ev_if.reply_kind <= pending_events[0].reply_kind;
          ev_if.error_code <= pending_events[0].error_code;
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rmsc_result_t exp_r;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          n_fail++;
        end else begin
          exp_r = expected_results.pop_front();
          n_results++;
          if (exp_r.ack_report == ACK_OK) n_acked++;
          if (exp_r.command == CMD_RESEND) n_resends++;
          check_field("command", int'(exp_r.command), int'(res_if.command));
          check_field("init_index", int'(exp_r.init_index), int'(res_if.init_index));
          check_field("port", int'(exp_r.port), int'(res_if.port));
          check_field("ack_report", int'(exp_r.ack_report), int'(res_if.ack_report));
          check_field("chip_enable", int'(exp_r.chip_enable), int'(res_if.chip_enable));
          check_field("session_state", int'(exp_r.session_state),
                      int'(res_if.session_state));
          check_field("connected", int'(exp_r.connected), int'(res_if.connected));
          check_field("request_accepted", int'(exp_r.request_accepted),
                      int'(res_if.request_accepted));
          check_field("payload_limit", int'(exp_r.payload_limit),
                      int'(res_if.payload_limit));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ev_if.valid = 1'b0;
    ev_if.op = OP_TICK;
    ev_if.reply_kind = RK_INIT_DONE;
    ev_if.error_code = '0;
    res_if.ready = 1'b0;
    calm = 1'b0;
    send_gap = 0;
    stall_left = 0;
    idle_cycles = 0;
    n_fail = 0;
    n_events = 0;
    n_results = 0;
    n_acked = 0;
    n_resends = 0;

    c_creds = 1'b0;
    c_timeout = RESP_TIMEOUT_RST;
    c_fast_wait = FAST_WAIT_RST;
    c_slow_wait = SLOW_WAIT_RST;
    c_max_resends = MAX_RESENDS_RST;
    c_fast_limit = FAST_LIMIT_RST;
    p_mode = M_OFF;
    p_init_step = '0;
    p_resends = '0;
    p_resets = '0;
    p_slow = 1'b0;
    p_ms_reply = '0;
    p_ms_off = '0;
    p_backup = 1'b0;
    p_port = '0;
    p_limit = LIMIT_DEFAULT;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // power-on after the fast wait with no start event
    repeat (11) queue_event({OP_TICK, RK_MALFORMED, 8'hFF});
    queue_event({OP_REPLY, RK_INIT_DONE, 8'h00});
    queue_event({OP_START, RK_INIT_DONE, 8'h00});
    queue_event({OP_RELOAD, RK_OK, 8'h00});
    queue_event({OP_REPLY, RK_DOWNLINK, 8'h00});
    queue_event({OP_REPLY, RK_MALFORMED, 8'hFF});
    queue_event({OP_REPLY, RK_ACK, 8'h00});
    queue_event({OP_REPLY, RK_OTHER, 8'h00});
    queue_event({OP_REPLY, RK_ERROR, ERR_IGNORE_A});
    queue_event({OP_REPLY, RK_ERROR, ERR_IGNORE_B});
    queue_event({OP_REPLY, RK_OK, 8'h00});
    // join success also counts as ok
    queue_event({OP_REPLY, RK_JOINED, 8'h00});
    // unknown code resets, then a reset while off is ignored
    queue_event({OP_REPLY, RK_ERROR, 8'hFF});
    queue_event({OP_REPLY, RK_ERROR, 8'h00});
    queue_event({3'd7, RK_MALFORMED, 8'hFF});
    queue_event({3'd5, RK_INIT_DONE, 8'h00});
    queue_event({OP_START, RK_INIT_DONE, 8'h00});
    queue_event({OP_TICK, RK_INIT_DONE, 8'h00});
    queue_event({OP_SEND, RK_INIT_DONE, 8'h00});

    apply_settings(1'b1, 1, 1, 1, 1, 0);
    queue_random(180);
    apply_settings(1'b1, 25, 4, 20, 7, 7);
    queue_random(220);
    apply_settings(1'b1, 1000000, 1000000, 4000000, 3, 1);
    queue_random(110);
    // shrink the payload limit down to its floor
    repeat (125) begin
      queue_event({OP_REPLY, RK_ERROR, ($urandom_range(0, 1) != 0) ? ERR_TOO_LONG : ERR_SIZE});
    end
    apply_settings(1'b0, 8, 2, 6, 2, 3);
    queue_random(60);
    apply_settings(1'b1, 12, 3, 9, 4, 2);
    calm = 1'b1;
    queue_random(230);
    drain();

    $display("covered %0d event transactions and %0d result transactions over six settings",
             n_events, n_results);
    $display("sends acknowledged: %0d, resends issued: %0d", n_acked, n_resends);
    if (n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
